@@ rtl/core/sla_pkg.sv @@
// Shared types and constants for the skyline atlas allocator.
// Holds the atlas geometry, the transfer payload structs and the sequencer states.
// Depends on nothing.
`default_nettype none

package sla_pkg;

  // Atlas geometry.
  localparam int ATLAS_SIZE = 1024;
  localparam int AW         = $clog2(ATLAS_SIZE);
  localparam int HW         = AW + 1;
  localparam int IN_W       = 11;
  localparam int POS_W      = 10;
  localparam int SUM_W      = ((HW > IN_W) ? HW : IN_W) + 1;

  // Request codes.
  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_CLEAR = 1'b1
  } action_t;

  // Input transfer payload.
  typedef struct packed {
    action_t           action;
    logic [IN_W-1:0]   rect_width;
    logic [IN_W-1:0]   rect_height;
  } sla_in_t;

  // Result transfer payload.
  typedef struct packed {
    logic              placed;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
  } sla_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BWD,
    ST_FWD,
    ST_DECIDE,
    ST_WRITE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/skyline_atlas_allocator_core.sv @@
// Skyline bottom-left atlas allocator: one height per column, placement by
// minimum window maximum. Depends on sla_pkg and sla_ram.
//
// The block takes one request at a time. An allocate request with a usable
// width runs two passes over the column memory, one column per cycle: a
// backward pass that stores per-block suffix maxima and a forward pass that
// forms per-block prefix maxima and combines them into every window maximum.
// A placement then writes the covered columns one per cycle. A rejected width
// is answered without a pass over the memory. A clear request sweeps the
// skyline memory. After reset a clearing pass runs, during which no input
// transfer is taken. A finished result waits in an output register, and the
// next request is taken while it waits.
`default_nettype none

module skyline_atlas_allocator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sla_pkg::sla_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sla_pkg::sla_out_t out_data
);
  import sla_pkg::*;

  // Control registers.
  state_t          state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic            iss_on_r, iss_on_nxt;
  logic            vld1_r, vld1_nxt;
  logic            reply_r, reply_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [AW-1:0]   idx1_r, idx1_nxt;
  logic [AW-1:0]   w_m1_r, w_m1_nxt;
  logic [IN_W-1:0] h_r, h_nxt;
  logic [HW-1:0]   run_r, run_nxt;
  logic [AW-1:0]   phase_r, phase_nxt;
  logic [HW-1:0]   best_r, best_nxt;
  logic [AW-1:0]   best_x_r, best_x_nxt;
  logic [HW-1:0]   new_h_r, new_h_nxt;
  sla_out_t        res_r, res_nxt;
  sla_out_t        out_r, out_nxt;

  // Memory ports.
  logic            col_we;
  logic [AW-1:0]   col_waddr;
  logic [HW-1:0]   col_wdata;
  logic [HW-1:0]   col_rdata;
  logic            suf_we;
  logic [AW-1:0]   suf_raddr;
  logic [HW-1:0]   suf_rdata;

  // Shared compare unit and derived values.
  logic [HW-1:0]   max_h;
  logic [HW-1:0]   run_b;
  logic [HW-1:0]   pre_f;
  logic [HW-1:0]   top_f;
  logic            win_ok;
  logic [AW-1:0]   cand_x;
  logic [SUM_W-1:0] sum;
  logic            bad_width;

  // Skyline heights, one per column.
  sla_ram #(
    .DEPTH (ATLAS_SIZE),
    .WIDTH (HW)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (addr_r),
    .rdata (col_rdata)
  );

  // Suffix maxima within each block of width columns.
  sla_ram #(
    .DEPTH (ATLAS_SIZE),
    .WIDTH (HW)
  ) u_suf_ram (
    .clk   (clk),
    .we    (suf_we),
    .waddr (idx1_r),
    .wdata (run_b),
    .raddr (suf_raddr),
    .rdata (suf_rdata)
  );

  assign suf_raddr = addr_r - w_m1_r;

  // The running maximum is fresh at a block's right end going backward and
  // at its left end going forward.
  assign max_h  = (col_rdata > run_r) ? col_rdata : run_r;
  assign run_b  = (phase_r == '0) ? col_rdata : max_h;
  assign pre_f  = (phase_r == w_m1_r) ? col_rdata : max_h;
  assign top_f  = (suf_rdata > pre_f) ? suf_rdata : pre_f;
  assign win_ok = (idx1_r >= w_m1_r);
  assign cand_x = idx1_r - w_m1_r;
  assign sum    = SUM_W'(best_r) + SUM_W'(h_r);

  assign bad_width = (in_data.rect_width == '0) ||
                     (SUM_W'(in_data.rect_width) >= SUM_W'(ATLAS_SIZE));

  // Sequencer: next state, datapath updates and memory controls.
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    iss_on_nxt    = iss_on_r;
    vld1_nxt      = 1'b0;
    idx1_nxt      = addr_r;
    reply_nxt     = reply_r;
    out_valid_nxt = out_valid_r;
    w_m1_nxt      = w_m1_r;
    h_nxt         = h_r;
    run_nxt       = run_r;
    phase_nxt     = phase_r;
    best_nxt      = best_r;
    best_x_nxt    = best_x_r;
    new_h_nxt     = new_h_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    col_we        = 1'b0;
    col_waddr     = addr_r;
    col_wdata     = '0;
    suf_we        = 1'b0;
    in_stall      = 1'b1;

    // A waiting result leaves once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        col_we = 1'b1;
        if (addr_r == AW'(ATLAS_SIZE - 1)) begin
          if (reply_r) begin
            res_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.action == ACT_CLEAR) begin
            addr_nxt  = '0;
            reply_nxt = 1'b1;
            state_nxt = ST_CLEAR;
          end else if (bad_width) begin
            res_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            w_m1_nxt   = AW'(in_data.rect_width - 1'b1);
            h_nxt      = in_data.rect_height;
            addr_nxt   = AW'(ATLAS_SIZE - 1);
            iss_on_nxt = 1'b1;
            phase_nxt  = '0;
            best_nxt   = HW'(ATLAS_SIZE);
            best_x_nxt = '0;
            state_nxt  = ST_BWD;
          end
        end
      end

      ST_BWD: begin
        // Issue columns from the right edge down to zero.
        if (iss_on_r) begin
          vld1_nxt = 1'b1;
          if (addr_r == '0) begin
            iss_on_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r - 1'b1;
          end
        end
        // Store the suffix maximum of the column that has arrived.
        if (vld1_r) begin
          suf_we  = 1'b1;
          run_nxt = run_b;
          if (idx1_r == '0) begin
            phase_nxt  = phase_r;
            addr_nxt   = '0;
            iss_on_nxt = 1'b1;
            state_nxt  = ST_FWD;
          end else if (phase_r == w_m1_r) begin
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
        end
      end

      ST_FWD: begin
        // Issue window end columns from zero up to the next-to-last column.
        if (iss_on_r) begin
          vld1_nxt = 1'b1;
          if (addr_r == AW'(ATLAS_SIZE - 2)) begin
            iss_on_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        // Combine prefix and suffix maxima; keep the lowest, leftmost window.
        if (vld1_r) begin
          run_nxt = pre_f;
          if (phase_r == '0) begin
            phase_nxt = w_m1_r;
          end else begin
            phase_nxt = phase_r - 1'b1;
          end
          if (win_ok && (top_f < best_r)) begin
            best_nxt   = top_f;
            best_x_nxt = cand_x;
          end
          if (idx1_r == AW'(ATLAS_SIZE - 2)) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if ((best_r == HW'(ATLAS_SIZE)) || (sum > SUM_W'(ATLAS_SIZE))) begin
          res_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          new_h_nxt = HW'(sum);
          addr_nxt  = best_x_r;
          state_nxt = ST_WRITE;
        end
      end

      ST_WRITE: begin
        col_we    = 1'b1;
        col_wdata = new_h_r;
        if (addr_r == (best_x_r + w_m1_r)) begin
          res_nxt.placed = 1'b1;
          res_nxt.pos_x  = POS_W'(best_x_r);
          res_nxt.pos_y  = POS_W'(best_r);
          state_nxt      = ST_EMIT;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          reply_nxt     = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state; reset starts the clearing pass at column zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      iss_on_r    <= 1'b0;
      vld1_r      <= 1'b0;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      iss_on_r    <= iss_on_nxt;
      vld1_r      <= vld1_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx1_r   <= idx1_nxt;
    w_m1_r   <= w_m1_nxt;
    h_r      <= h_nxt;
    run_r    <= run_nxt;
    phase_r  <= phase_nxt;
    best_r   <= best_nxt;
    best_x_r <= best_x_nxt;
    new_h_r  <= new_h_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ rtl/core/sla_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// Used for the skyline heights and for the block suffix maxima.
// Depends on nothing.
`default_nettype none

module sla_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
